@@ rtl/core/tkpds_pkg.sv @@
package tkpds_pkg;

  localparam int MaxLights  = 8;
  localparam int ResultCap  = 8;
  localparam int NumOut     = (MaxLights < ResultCap) ? MaxLights : ResultCap;
  localparam int SlotIdxW   = (MaxLights > 1) ? $clog2(MaxLights) : 1;
  localparam int CntW       = $clog2(MaxLights + 1);
  localparam int OutIdxW    = (NumOut > 1) ? $clog2(NumOut) : 1;

  localparam int IdW        = 10;
  localparam int PrioW      = 8;
  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int DistW      = 36;
  localparam int SlotIndexW = 3;
  localparam int CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX = 2'd0,
    CfgCenterY = 2'd1,
    CfgCenterZ = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef struct packed {
    logic                load;
    logic                mul_en;
    axis_e               axis;
    logic [SlotIdxW-1:0] rd_idx;
    logic                shift_we;
    logic                ins_we;
    logic [SlotIdxW-1:0] wr_idx;
    logic                fill_inc;
    logic                fill_clr;
    logic [OutIdxW-1:0]  out_idx;
  } cmd_t;

  typedef struct packed {
    logic            shift_ok;
    logic            final_item;
    logic [CntW-1:0] filled;
  } sts_t;

endpackage

@@ rtl/core/tkpds_in_if.sv @@
interface tkpds_in_if;
  logic                                valid;
  logic                                ready;
  logic [tkpds_pkg::IdW-1:0]           light_id;
  logic [tkpds_pkg::PrioW-1:0]         priority_req;
  logic signed [tkpds_pkg::CoordW-1:0] pos_x;
  logic signed [tkpds_pkg::CoordW-1:0] pos_y;
  logic signed [tkpds_pkg::CoordW-1:0] pos_z;
  logic                                final_item;

  modport source (
    output valid, light_id, priority_req, pos_x, pos_y, pos_z, final_item,
    input  ready
  );
  modport sink (
    input  valid, light_id, priority_req, pos_x, pos_y, pos_z, final_item,
    output ready
  );
endinterface

@@ rtl/core/tkpds_out_if.sv @@
interface tkpds_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [tkpds_pkg::SlotIndexW-1:0]     slot_index;
  logic [tkpds_pkg::IdW-1:0]            selected_id;
  logic                                 slot_valid;
  logic                                 run_end;

  modport source (
    output valid, slot_index, selected_id, slot_valid, run_end,
    input  ready
  );
  modport sink (
    input  valid, slot_index, selected_id, slot_valid, run_end,
    output ready
  );
endinterface

@@ rtl/core/tkpds_ctrl.sv @@
module tkpds_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tkpds_pkg::sts_t    sts_i,
  output tkpds_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDist = 4'b0010,
    StWalk = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  tkpds_pkg::axis_e                axis_q, axis_d;
  logic [tkpds_pkg::CntW-1:0]      pos_q, pos_d;
  logic [tkpds_pkg::OutIdxW-1:0]   k_q, k_d;
  logic [tkpds_pkg::CntW-1:0]      pos_m1;
  logic                            pos_lt_max;
  logic                            k_last;

  assign pos_m1     = pos_q - 1'b1;
  assign pos_lt_max = pos_q < tkpds_pkg::CntW'(tkpds_pkg::MaxLights);
  assign k_last     = k_q == tkpds_pkg::OutIdxW'(tkpds_pkg::NumOut - 1);

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StEmit;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    pos_d   = pos_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.axis    = axis_q;
    cmd_o.out_idx = k_q;
    cmd_o.wr_idx  = pos_q[tkpds_pkg::SlotIdxW-1:0];
    if (state_q == StEmit) begin
      cmd_o.rd_idx = tkpds_pkg::SlotIdxW'(k_q);
    end else begin
      cmd_o.rd_idx = pos_m1[tkpds_pkg::SlotIdxW-1:0];
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = tkpds_pkg::AxisX;
          state_d    = StDist;
        end
      end
      StDist: begin
        cmd_o.mul_en = 1'b1;
        case (axis_q)
          tkpds_pkg::AxisX: axis_d = tkpds_pkg::AxisY;
          tkpds_pkg::AxisY: axis_d = tkpds_pkg::AxisZ;
          default: begin
            pos_d   = sts_i.filled;
            state_d = StWalk;
          end
        endcase
      end
      StWalk: begin
        if (pos_q == '0 || !sts_i.shift_ok) begin
          cmd_o.ins_we   = pos_lt_max;
          cmd_o.fill_inc = 1'b1;
          k_d            = '0;
          state_d        = sts_i.final_item ? StEmit : StIdle;
        end else begin
          cmd_o.shift_we = pos_lt_max;
          pos_d          = pos_m1;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          if (k_last) begin
            cmd_o.fill_clr = 1'b1;
            state_d        = StIdle;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= tkpds_pkg::AxisX;
      pos_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
    end
  end

endmodule

@@ rtl/core/tkpds_dp.sv @@
module tkpds_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tkpds_pkg::cmd_t                       cmd_i,
  output tkpds_pkg::sts_t                       sts_o,
  input  logic                                  cfg_we_i,
  input  logic [tkpds_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [tkpds_pkg::CoordW-1:0]          cfg_wdata_i,
  input  logic [tkpds_pkg::IdW-1:0]             light_id_i,
  input  logic [tkpds_pkg::PrioW-1:0]           priority_req_i,
  input  logic signed [tkpds_pkg::CoordW-1:0]   pos_x_i,
  input  logic signed [tkpds_pkg::CoordW-1:0]   pos_y_i,
  input  logic signed [tkpds_pkg::CoordW-1:0]   pos_z_i,
  input  logic                                  final_item_i,
  output logic [tkpds_pkg::SlotIndexW-1:0]      slot_index_o,
  output logic [tkpds_pkg::IdW-1:0]             selected_id_o,
  output logic                                  slot_valid_o,
  output logic                                  run_end_o
);

  logic signed [tkpds_pkg::CoordW-1:0] center_x_q, center_y_q, center_z_q;

  logic [tkpds_pkg::IdW-1:0]           id_q;
  logic [tkpds_pkg::PrioW-1:0]         prio_q;
  logic signed [tkpds_pkg::CoordW-1:0] px_q, py_q, pz_q;
  logic                                final_q;

  logic [tkpds_pkg::DistW-1:0]         acc_q, acc_d;
  logic signed [tkpds_pkg::CoordW-1:0] p_sel, c_sel;
  logic signed [tkpds_pkg::DiffW-1:0]  diff;
  logic signed [tkpds_pkg::SqW-1:0]    sq;

  logic [tkpds_pkg::IdW-1:0]   slot_ident [tkpds_pkg::MaxLights];
  logic [tkpds_pkg::PrioW-1:0] slot_prio  [tkpds_pkg::MaxLights];
  logic [tkpds_pkg::DistW-1:0] slot_dist  [tkpds_pkg::MaxLights];

  logic [tkpds_pkg::IdW-1:0]   rd_ident;
  logic [tkpds_pkg::PrioW-1:0] rd_prio;
  logic [tkpds_pkg::DistW-1:0] rd_dist;

  logic [tkpds_pkg::CntW-1:0]  filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tkpds_pkg::CfgCenterX) center_x_q <= cfg_wdata_i;
      if (cfg_idx_i == tkpds_pkg::CfgCenterY) center_y_q <= cfg_wdata_i;
      if (cfg_idx_i == tkpds_pkg::CfgCenterZ) center_z_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= light_id_i;
      prio_q  <= priority_req_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      pz_q    <= pos_z_i;
      final_q <= final_item_i;
    end
  end

  always_comb begin
    case (cmd_i.axis)
      tkpds_pkg::AxisX: begin
        p_sel = px_q;
        c_sel = center_x_q;
      end
      tkpds_pkg::AxisY: begin
        p_sel = py_q;
        c_sel = center_y_q;
      end
      tkpds_pkg::AxisZ: begin
        p_sel = pz_q;
        c_sel = center_z_q;
      end
      default: begin
        p_sel = '0;
        c_sel = '0;
      end
    endcase
  end

  assign diff  = {p_sel[tkpds_pkg::CoordW-1], p_sel} - {c_sel[tkpds_pkg::CoordW-1], c_sel};
  assign sq    = tkpds_pkg::SqW'(diff) * tkpds_pkg::SqW'(diff);
  assign acc_d = acc_q + {{(tkpds_pkg::DistW - tkpds_pkg::SqW){1'b0}}, $unsigned(sq)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
  end

  assign rd_ident = slot_ident[cmd_i.rd_idx];
  assign rd_prio  = slot_prio[cmd_i.rd_idx];
  assign rd_dist  = slot_dist[cmd_i.rd_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_we) begin
      slot_ident[cmd_i.wr_idx] <= rd_ident;
      slot_prio[cmd_i.wr_idx]  <= rd_prio;
      slot_dist[cmd_i.wr_idx]  <= rd_dist;
    end else if (cmd_i.ins_we) begin
      slot_ident[cmd_i.wr_idx] <= id_q;
      slot_prio[cmd_i.wr_idx]  <= prio_q;
      slot_dist[cmd_i.wr_idx]  <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (cmd_i.fill_clr) begin
      filled_q <= '0;
    end else if (cmd_i.fill_inc &&
                 filled_q < tkpds_pkg::CntW'(tkpds_pkg::MaxLights)) begin
      filled_q <= filled_q + 1'b1;
    end
  end

  assign sts_o.shift_ok   = (prio_q > rd_prio) || (prio_q == rd_prio && acc_q <= rd_dist);
  assign sts_o.final_item = final_q;
  assign sts_o.filled     = filled_q;

  assign slot_valid_o  = tkpds_pkg::CntW'(cmd_i.out_idx) < filled_q;
  assign selected_id_o = slot_valid_o ? rd_ident : '0;
  assign slot_index_o  = tkpds_pkg::SlotIndexW'(cmd_i.out_idx);
  assign run_end_o     = cmd_i.out_idx == tkpds_pkg::OutIdxW'(tkpds_pkg::NumOut - 1);

endmodule

@@ rtl/core/top_k_priority_distance_select.sv @@
// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    light_id, priority_req, pos_x/y/z, final_item
// out_o     out  valid/ready    slot_index, selected_id, slot_valid, run_end
// cfg       in   cfg_we_i       cfg_idx_i selects center x/y/z, cfg_wdata_i
//
// Each item is taken in, then its squared distance is summed on the shared squaring
// multiplier (one axis a cycle, x then y then z), then the slots are walked to place it.
// A final item then sends NumOut words, one per cycle while out_o is ready.
// in_i stays not ready until the item and any words it causes are done.
// Reset clears the centre, the fill count and the controller; slots are
// not cleared and are read only below the fill count.
module top_k_priority_distance_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tkpds_in_if.sink                            in_i,
  tkpds_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [tkpds_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tkpds_pkg::CoordW-1:0]        cfg_wdata_i
);

  tkpds_pkg::cmd_t cmd;
  tkpds_pkg::sts_t sts;

  tkpds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tkpds_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .light_id_i     (in_i.light_id),
    .priority_req_i (in_i.priority_req),
    .pos_x_i        (in_i.pos_x),
    .pos_y_i        (in_i.pos_y),
    .pos_z_i        (in_i.pos_z),
    .final_item_i   (in_i.final_item),
    .slot_index_o   (out_o.slot_index),
    .selected_id_o  (out_o.selected_id),
    .slot_valid_o   (out_o.slot_valid),
    .run_end_o      (out_o.run_end)
  );

endmodule
